// ----- sv/sfdd_pkg.sv -----
// Types, constants and register map shared by the drive controller files.
`timescale 1ns / 1ps
`default_nettype none

package sfdd_pkg;

  // Field widths
  localparam int SampleW = 16;           // every input sample field
  localparam int GainW   = 24;           // signed gains, volts per LSB * 2^24
  localparam int ErrW    = SampleW + 1;  // exact difference of two samples
  localparam int ProdW   = ErrW + GainW; // exact error * gain
  localparam int SumW    = ProdW + 2;    // exact sum of four products
  localparam int FracW   = 16;           // shift from sum to 1/256 V
  localparam int VoltW   = SumW - FracW; // voltage before clamping
  localparam int DriveW  = 13;           // drive_voltage port width
  localparam int StatW   = 2;
  localparam int WinW    = 15;
  localparam int DbandW  = 12;
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 24;

  localparam logic signed [VoltW-1:0] VoltLimit = VoltW'(3072);

  // Register map
  localparam logic [CfgIdxW-1:0] RegGainCartPosition  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegGainPendulumAngle = 4'd1;
  localparam logic [CfgIdxW-1:0] RegGainCartVelocity  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegGainPendulumRate  = 4'd3;
  localparam logic [CfgIdxW-1:0] RegAngleTarget       = 4'd4;
  localparam logic [CfgIdxW-1:0] RegPositionWindow    = 4'd5;
  localparam logic [CfgIdxW-1:0] RegAngleWindow       = 4'd6;
  localparam logic [CfgIdxW-1:0] RegVoltageDeadband   = 4'd7;

  // Reset values
  localparam logic signed [GainW-1:0]   RstGainCartPosition  = 24'sd29308;
  localparam logic signed [GainW-1:0]   RstGainPendulumAngle = 24'sd82458;
  localparam logic signed [GainW-1:0]   RstGainCartVelocity  = 24'sd15258;
  localparam logic signed [GainW-1:0]   RstGainPendulumRate  = -24'sd8677;
  localparam logic signed [SampleW-1:0] RstAngleTarget       = 16'sd12868;
  localparam logic [WinW-1:0]           RstPositionWindow    = 15'd256;
  localparam logic [WinW-1:0]           RstAngleWindow       = 15'd71;
  localparam logic [DbandW-1:0]         RstVoltageDeadband   = 12'd256;

  // drive_status codes
  localparam logic [StatW-1:0] StatNormal   = 2'd0;
  localparam logic [StatW-1:0] StatWindow   = 2'd1;
  localparam logic [StatW-1:0] StatDeadband = 2'd2;
  localparam logic [StatW-1:0] StatClamped  = 2'd3;

  typedef logic signed [ErrW-1:0]  err_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [VoltW-1:0] volt_t;

  typedef struct packed {
    logic signed [GainW-1:0]   gain_cart_position;
    logic signed [GainW-1:0]   gain_pendulum_angle;
    logic signed [GainW-1:0]   gain_cart_velocity;
    logic signed [GainW-1:0]   gain_pendulum_rate;
    logic signed [SampleW-1:0] angle_target;
    logic [WinW-1:0]           position_window;
    logic [WinW-1:0]           angle_window;
    logic [DbandW-1:0]         voltage_deadband;
  } cfg_t;

endpackage : sfdd_pkg

`default_nettype wire

// ----- sv/sfdd_ifs.sv -----
// Handshake channel interfaces for samples, drive results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface sfdd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sfdd_pkg::SampleW-1:0] cart_pos;
  logic signed [sfdd_pkg::SampleW-1:0] cart_target;
  logic signed [sfdd_pkg::SampleW-1:0] cart_vel;
  logic signed [sfdd_pkg::SampleW-1:0] pend_ang;
  logic signed [sfdd_pkg::SampleW-1:0] pend_rate;

  modport source (output valid, cart_pos, cart_target, cart_vel, pend_ang, pend_rate,
                  input ready);
  modport sink   (input valid, cart_pos, cart_target, cart_vel, pend_ang, pend_rate,
                  output ready);
endinterface : sfdd_in_if

interface sfdd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sfdd_pkg::DriveW-1:0] drive_voltage;
  logic [sfdd_pkg::StatW-1:0]         drive_status;

  modport source (output valid, drive_voltage, drive_status, input ready);
  modport sink   (input valid, drive_voltage, drive_status, output ready);
endinterface : sfdd_out_if

interface sfdd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfdd_pkg::CfgIdxW-1:0] index;
  logic [sfdd_pkg::CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : sfdd_cfg_if

`default_nettype wire

// ----- sv/sfdd_cfg_regs.sv -----
// Configuration register file for the drive controller.
`timescale 1ns / 1ps
`default_nettype none

module sfdd_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  sfdd_cfg_if.sink          cfg_ch,
  output sfdd_pkg::cfg_t    cfg
);
  import sfdd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken; indexes past the map drop silently.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        RegGainCartPosition:  cfg_nxt.gain_cart_position  = cfg_ch.data[GainW-1:0];
        RegGainPendulumAngle: cfg_nxt.gain_pendulum_angle = cfg_ch.data[GainW-1:0];
        RegGainCartVelocity:  cfg_nxt.gain_cart_velocity  = cfg_ch.data[GainW-1:0];
        RegGainPendulumRate:  cfg_nxt.gain_pendulum_rate  = cfg_ch.data[GainW-1:0];
        RegAngleTarget:       cfg_nxt.angle_target        = cfg_ch.data[SampleW-1:0];
        RegPositionWindow:    cfg_nxt.position_window     = cfg_ch.data[WinW-1:0];
        RegAngleWindow:       cfg_nxt.angle_window        = cfg_ch.data[WinW-1:0];
        RegVoltageDeadband:   cfg_nxt.voltage_deadband    = cfg_ch.data[DbandW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_cart_position  <= RstGainCartPosition;
      cfg_r.gain_pendulum_angle <= RstGainPendulumAngle;
      cfg_r.gain_cart_velocity  <= RstGainCartVelocity;
      cfg_r.gain_pendulum_rate  <= RstGainPendulumRate;
      cfg_r.angle_target        <= RstAngleTarget;
      cfg_r.position_window     <= RstPositionWindow;
      cfg_r.angle_window        <= RstAngleWindow;
      cfg_r.voltage_deadband    <= RstVoltageDeadband;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule : sfdd_cfg_regs

`default_nettype wire

// ----- sv/state_feedback_drive_with_deadzone.sv -----
// Top level: full-state-feedback motor drive with window, deadband and clamp.
// Path: an input transfer is registered through stage 1, stage 2 and the stage 3 result register.
// Throughput: one sample per cycle; the three stages stall together only while
//   a finished result waits on out_ch.ready.
// Reset (rst_n low, synchronous): all stage valid flags clear, gains, target,
//   windows and deadband return to their default values.
`timescale 1ns / 1ps
`default_nettype none

module state_feedback_drive_with_deadzone (
  input  wire logic clk,
  input  wire logic rst_n,
  sfdd_in_if.sink   in_ch,
  sfdd_out_if.source out_ch,
  sfdd_cfg_if.sink  cfg_ch
);
  import sfdd_pkg::*;

  cfg_t cfg;

  sfdd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // The whole pipe advances unless the result register holds an untaken result.
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------------------------------------------------------------------
  // Stage 1: errors against the setpoints. Speed targets are zero, so the
  // speed errors are plain negations.
  // ---------------------------------------------------------------------------
  logic s1_vld_r;
  err_t e_pos_r, e_ang_r, e_vel_r, e_rate_r;
  err_t e_pos_nxt, e_ang_nxt, e_vel_nxt, e_rate_nxt;

  always_comb begin
    e_pos_nxt  = ErrW'(in_ch.cart_target) - ErrW'(in_ch.cart_pos);
    e_ang_nxt  = ErrW'(cfg.angle_target) - ErrW'(in_ch.pend_ang);
    e_vel_nxt  = -ErrW'(in_ch.cart_vel);
    e_rate_nxt = -ErrW'(in_ch.pend_rate);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_pos_r  <= e_pos_nxt;
      e_ang_r  <= e_ang_nxt;
      e_vel_r  <= e_vel_nxt;
      e_rate_r <= e_rate_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: four exact products and the state window test. Both errors must
  // lie strictly inside their half-widths; a window of zero never matches.
  // ---------------------------------------------------------------------------
  logic  s2_vld_r;
  logic  in_win_r, in_win_nxt;
  prod_t p_pos_r, p_ang_r, p_vel_r, p_rate_r;
  prod_t p_pos_nxt, p_ang_nxt, p_vel_nxt, p_rate_nxt;
  logic signed [ErrW:0] pos_e_x, ang_e_x, pos_w_x, ang_w_x;

  always_comb begin
    pos_e_x    = (ErrW+1)'(e_pos_r);
    ang_e_x    = (ErrW+1)'(e_ang_r);
    pos_w_x    = $signed({{(ErrW+1-WinW){1'b0}}, cfg.position_window});
    ang_w_x    = $signed({{(ErrW+1-WinW){1'b0}}, cfg.angle_window});
    in_win_nxt = (pos_e_x < pos_w_x) && (pos_e_x > -pos_w_x) &&
                 (ang_e_x < ang_w_x) && (ang_e_x > -ang_w_x);
    p_pos_nxt  = prod_t'(e_pos_r)  * prod_t'(cfg.gain_cart_position);
    p_ang_nxt  = prod_t'(e_ang_r)  * prod_t'(cfg.gain_pendulum_angle);
    p_vel_nxt  = prod_t'(e_vel_r)  * prod_t'(cfg.gain_cart_velocity);
    p_rate_nxt = prod_t'(e_rate_r) * prod_t'(cfg.gain_pendulum_rate);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_win_r <= in_win_nxt;
      p_pos_r  <= p_pos_nxt;
      p_ang_r  <= p_ang_nxt;
      p_vel_r  <= p_vel_nxt;
      p_rate_r <= p_rate_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum, floor shift to 1/256 V (a plain bit-select of the two's
  // complement sum), then window, deadband and clamp in that priority.
  // ---------------------------------------------------------------------------
  logic                     out_vld_r;
  logic signed [DriveW-1:0] volt_r, volt_nxt;
  logic [StatW-1:0]         stat_r, stat_nxt;
  sum_t                     sum;
  volt_t                    v;
  volt_t                    dband_x;

  always_comb begin
    sum     = sum_t'(p_pos_r) + sum_t'(p_ang_r) + sum_t'(p_vel_r) + sum_t'(p_rate_r);
    v       = sum[SumW-1:FracW];
    dband_x = $signed({{(VoltW-DbandW){1'b0}}, cfg.voltage_deadband});
    if (in_win_r) begin
      volt_nxt = '0;
      stat_nxt = StatWindow;
    end else if ((v < dband_x) && (v > -dband_x)) begin
      volt_nxt = '0;
      stat_nxt = StatDeadband;
    end else if (v > VoltLimit) begin
      volt_nxt = VoltLimit[DriveW-1:0];
      stat_nxt = StatClamped;
    end else if (v < -VoltLimit) begin
      volt_nxt = DriveW'(-VoltLimit);
      stat_nxt = StatClamped;
    end else begin
      volt_nxt = v[DriveW-1:0];
      stat_nxt = StatNormal;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s2_vld_r;
    end
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (adv) begin
      volt_r <= volt_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.drive_voltage = volt_r;
  assign out_ch.drive_status  = stat_r;

`ifndef SYNTHESIS
  // A transfer in always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_vld_r)
    else $error("accepted sample did not enter stage 1");

  // Zeroing codes carry a zero voltage.
  a_zero_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.drive_status == StatWindow ||
                     out_ch.drive_status == StatDeadband) |-> out_ch.drive_voltage == '0)
    else $error("zeroed result carries a nonzero voltage");

  // Clamped results sit exactly on a rail.
  a_clamp_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.drive_status == StatClamped |->
      (out_ch.drive_voltage == VoltLimit[DriveW-1:0] ||
       out_ch.drive_voltage == DriveW'(-VoltLimit)))
    else $error("clamped result off the rail");

  // Every result stays within the rails.
  a_volt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (VoltW'(out_ch.drive_voltage) <= VoltLimit &&
                      VoltW'(out_ch.drive_voltage) >= -VoltLimit))
    else $error("drive voltage beyond the rails");
`endif

endmodule : state_feedback_drive_with_deadzone

`default_nettype wire
